// ===== rtl/bfca_pkg.sv =====
// Shared types for the best-fit coalescing allocator.
// Command and status structs between controller and datapath, result codes.
// No dependencies.
package bfca_pkg;

  localparam int IdxW = 10;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_BYTES = 3'd1,
    ST_NO_FIT   = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_SET_RES,
    CMD_SLOT,
    CMD_FREAD,
    CMD_FCALC,
    CMD_FEVAL,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_FCOPY,
    CMD_LREAD,
    CMD_LEVAL,
    CMD_PEVAL,
    CMD_MERGE_BOTH,
    CMD_MERGE_PREV,
    CMD_MERGE_NEXT,
    CMD_INSERT,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e            op;
    status_e         code;
    logic [IdxW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic            is_free;
    logic            addr_zero;
    logic            no_room;
    logic            live_free;
    logic            best_ok;
    logic            slot_ok;
    logic            split_ok;
    logic            live_match;
    logic            below;
    logic            join_prev;
    logic            join_next;
    logic            full;
    logic            out_busy;
    logic [IdxW-1:0] cnt;
    logic [IdxW-1:0] best_idx;
  } dp_stat_t;

endpackage

// ===== rtl/bfca_datapath.sv =====
// Datapath: free extent and live record memories, arithmetic, output register.
// Driven by bfca_controller through bfca_pkg::dp_cmd_t; depends on bfca_pkg.
module bfca_datapath #(
  parameter int ADDR_BITS       = 20,
  parameter int FREE_DEPTH      = 32,
  parameter int LIVE_DEPTH      = 64,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_BLOCK_BYTES = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ADDR_BITS:0]       cfg_wdata_i,
  input  logic                     req_type_i,
  input  logic [ADDR_BITS:0]       req_size_i,
  input  logic [3:0]               align_log2_i,
  input  logic [ADDR_BITS-1:0]     free_addr_i,
  input  bfca_pkg::dp_cmd_t        cmd_i,
  output bfca_pkg::dp_stat_t       stat_o,
  input  logic                     m_tready_i,
  output logic                     m_tvalid_o,
  output logic [2:0]               m_status_o,
  output logic [ADDR_BITS-1:0]     m_data_addr_o,
  output logic [ADDR_BITS:0]       m_granted_o,
  output logic [ADDR_BITS:0]       m_free_o
);

  localparam int AB  = ADDR_BITS;
  localparam int FAW = $clog2(FREE_DEPTH);
  localparam int LAW = $clog2(LIVE_DEPTH);
  localparam int CNW = $clog2(FREE_DEPTH + 1);
  localparam int XW  = ((AB + 1 > 16) ? AB + 1 : 16) + 2;
  localparam logic [AB:0] ArenaMax = {1'b1, {AB{1'b0}}};

  logic [AB-1:0] fb_mem [FREE_DEPTH];
  logic [AB:0]   fl_mem [FREE_DEPTH];
  logic [AB-1:0] ld_mem [LIVE_DEPTH];
  logic [AB-1:0] lb_mem [LIVE_DEPTH];
  logic [AB:0]   ll_mem [LIVE_DEPTH];

  logic [AB:0]           arena_q, inuse_q;
  logic [CNW-1:0]        cnt_q;
  logic                  ov_q, rd_ov_q, lrd_v_q;
  logic [LIVE_DEPTH-1:0] lvalid_q;
  logic                  best_ok_q, slot_ok_q, prev_ok_q, next_ok_q, out_valid_q;

  logic          rtype_q;
  logic [AB:0]   size_q;
  logic [3:0]    alog_q;
  logic [AB-1:0] faddr_q;
  logic [AB-1:0] rd_base_q;
  logic [AB:0]   rd_len_q;
  logic [XW-1:0] d_q;
  logic [FAW-1:0] best_idx_q;
  logic [AB-1:0] best_base_q, best_data_q;
  logic [AB:0]   best_len_q;
  logic [XW-1:0] best_need_q;
  logic [LAW-1:0] slot_q;
  logic [AB-1:0] lrd_do_q, lrd_bo_q;
  logic [AB:0]   lrd_ln_q;
  logic [AB-1:0] fblk_base_q, prev_base_q, next_base_q;
  logic [AB:0]   fblk_len_q, prev_len_q, next_len_q;
  logic [2:0]    res_st_q, m_st_q;
  logic [AB-1:0] res_da_q, m_da_q;
  logic [AB:0]   res_gb_q, m_gb_q, m_fb_q;

  logic [XW-1:0]  amask, tot, dcalc, needc;
  logic [AB:0]    freeb, rlen;
  logic [AB-1:0]  rbase;
  logic           fits, live_match, free_op;
  logic           fr_en, lr_en, fw_en, lw_en;
  logic [FAW-1:0] fr_addr, fw_addr;
  logic [LAW-1:0] lr_addr;
  logic [AB-1:0]  fw_base;
  logic [AB:0]    fw_len, glen;
  logic [AB:0]    size_in, cfg_sat;

  assign amask   = (XW'(1) << alog_q) - XW'(1);
  assign tot     = (XW'(size_q) + XW'(HEADER_BYTES) + amask) & ~amask;
  assign freeb   = arena_q - inuse_q;
  assign rbase   = rd_ov_q ? '0 : rd_base_q;
  assign rlen    = rd_ov_q ? arena_q : rd_len_q;
  assign dcalc   = (XW'(rbase) + XW'(HEADER_BYTES) + amask) & ~amask;
  assign needc   = d_q - XW'(rbase) + XW'(size_q);
  assign fits    = (XW'(rlen) >= needc) && (!best_ok_q || (rlen < best_len_q));
  assign live_match = lrd_v_q && (lrd_do_q == faddr_q);
  assign size_in = (req_size_i == '0) ? (AB+1)'(1) : req_size_i;
  assign cfg_sat = (cfg_wdata_i > ArenaMax) ? ArenaMax : cfg_wdata_i;
  assign glen    = (cmd_i.op == bfca_pkg::CMD_SPLIT) ? best_need_q[AB:0] : best_len_q;

  assign fr_en   = (cmd_i.op == bfca_pkg::CMD_FREAD);
  assign fr_addr = cmd_i.idx[FAW-1:0];
  assign lr_en   = (cmd_i.op == bfca_pkg::CMD_LREAD);
  assign lr_addr = cmd_i.idx[LAW-1:0];
  assign lw_en   = (cmd_i.op == bfca_pkg::CMD_SPLIT) || (cmd_i.op == bfca_pkg::CMD_TAKE);
  assign free_op = (cmd_i.op == bfca_pkg::CMD_MERGE_BOTH) ||
                   (cmd_i.op == bfca_pkg::CMD_MERGE_PREV) ||
                   (cmd_i.op == bfca_pkg::CMD_MERGE_NEXT) ||
                   (cmd_i.op == bfca_pkg::CMD_INSERT);

  always_comb begin
    fw_en   = 1'b1;
    fw_addr = cmd_i.idx[FAW-1:0];
    fw_base = prev_base_q;
    fw_len  = prev_len_q + fblk_len_q;
    unique case (cmd_i.op)
      bfca_pkg::CMD_SPLIT: begin
        fw_addr = best_idx_q;
        fw_base = best_base_q + best_need_q[AB-1:0];
        fw_len  = best_len_q - best_need_q[AB:0];
      end
      bfca_pkg::CMD_FCOPY: begin
        fw_base = rbase;
        fw_len  = rlen;
      end
      bfca_pkg::CMD_MERGE_BOTH: begin
        fw_len = prev_len_q + fblk_len_q + next_len_q;
      end
      bfca_pkg::CMD_MERGE_PREV: begin
        fw_len = prev_len_q + fblk_len_q;
      end
      bfca_pkg::CMD_MERGE_NEXT: begin
        fw_base = fblk_base_q;
        fw_len  = next_len_q + fblk_len_q;
      end
      bfca_pkg::CMD_INSERT: begin
        fw_base = fblk_base_q;
        fw_len  = fblk_len_q;
      end
      default: fw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) begin
      fb_mem[fw_addr] <= fw_base;
      fl_mem[fw_addr] <= fw_len;
    end
    if (fr_en) begin
      rd_base_q <= fb_mem[fr_addr];
      rd_len_q  <= fl_mem[fr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      ld_mem[slot_q] <= best_data_q;
      lb_mem[slot_q] <= best_base_q;
      ll_mem[slot_q] <= glen;
    end
    if (lr_en) begin
      lrd_do_q <= ld_mem[lr_addr];
      lrd_bo_q <= lb_mem[lr_addr];
      lrd_ln_q <= ll_mem[lr_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q     <= ArenaMax;
      inuse_q     <= '0;
      cnt_q       <= CNW'(1);
      ov_q        <= 1'b1;
      rd_ov_q     <= 1'b0;
      lrd_v_q     <= 1'b0;
      lvalid_q    <= '0;
      best_ok_q   <= 1'b0;
      slot_ok_q   <= 1'b0;
      prev_ok_q   <= 1'b0;
      next_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      arena_q  <= cfg_sat;
      inuse_q  <= '0;
      cnt_q    <= (cfg_sat != '0) ? CNW'(1) : '0;
      ov_q     <= 1'b1;
      lvalid_q <= '0;
    end else begin
      if (fw_en && (fw_addr == '0)) ov_q <= 1'b0;
      if (free_op) begin
        lvalid_q[slot_q] <= 1'b0;
        inuse_q          <= inuse_q - fblk_len_q;
      end
      if (m_tready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        bfca_pkg::CMD_LATCH: begin
          best_ok_q <= 1'b0;
          slot_ok_q <= 1'b0;
          prev_ok_q <= 1'b0;
          next_ok_q <= 1'b0;
        end
        bfca_pkg::CMD_SLOT:  if (!lvalid_q[lr_addr]) slot_ok_q <= 1'b1;
        bfca_pkg::CMD_FREAD: rd_ov_q <= ov_q && (fr_addr == '0);
        bfca_pkg::CMD_FEVAL: if (fits) best_ok_q <= 1'b1;
        bfca_pkg::CMD_SPLIT, bfca_pkg::CMD_TAKE: begin
          lvalid_q[slot_q] <= 1'b1;
          inuse_q          <= inuse_q + glen;
          if (cmd_i.op == bfca_pkg::CMD_TAKE) cnt_q <= cnt_q - CNW'(1);
        end
        bfca_pkg::CMD_MERGE_BOTH: cnt_q <= cnt_q - CNW'(1);
        bfca_pkg::CMD_INSERT:     cnt_q <= cnt_q + CNW'(1);
        bfca_pkg::CMD_LREAD: lrd_v_q <= lvalid_q[lr_addr];
        bfca_pkg::CMD_PEVAL: begin
          if (rbase < fblk_base_q) prev_ok_q <= 1'b1;
          else next_ok_q <= 1'b1;
        end
        bfca_pkg::CMD_RESULT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_op) begin
      res_st_q <= bfca_pkg::ST_OK;
      res_da_q <= '0;
      res_gb_q <= fblk_len_q;
    end
    case (cmd_i.op)
      bfca_pkg::CMD_LATCH: begin
        rtype_q <= req_type_i;
        size_q  <= size_in;
        alog_q  <= align_log2_i;
        faddr_q <= free_addr_i;
      end
      bfca_pkg::CMD_SET_RES: begin
        res_st_q <= cmd_i.code;
        res_da_q <= '0;
        res_gb_q <= '0;
      end
      bfca_pkg::CMD_SLOT: if (!lvalid_q[lr_addr]) slot_q <= lr_addr;
      bfca_pkg::CMD_FCALC: d_q <= dcalc;
      bfca_pkg::CMD_FEVAL: begin
        if (fits) begin
          best_idx_q  <= cmd_i.idx[FAW-1:0];
          best_base_q <= rbase;
          best_len_q  <= rlen;
          best_need_q <= needc;
          best_data_q <= d_q[AB-1:0];
        end
      end
      bfca_pkg::CMD_SPLIT, bfca_pkg::CMD_TAKE: begin
        res_st_q <= bfca_pkg::ST_OK;
        res_da_q <= best_data_q;
        res_gb_q <= glen;
      end
      bfca_pkg::CMD_LEVAL: begin
        if (live_match) begin
          slot_q      <= cmd_i.idx[LAW-1:0];
          fblk_base_q <= lrd_bo_q;
          fblk_len_q  <= lrd_ln_q;
        end
      end
      bfca_pkg::CMD_PEVAL: begin
        if (rbase < fblk_base_q) begin
          prev_base_q <= rbase;
          prev_len_q  <= rlen;
        end else begin
          next_base_q <= rbase;
          next_len_q  <= rlen;
        end
      end
      bfca_pkg::CMD_RESULT: begin
        m_st_q <= res_st_q;
        m_da_q <= res_da_q;
        m_gb_q <= res_gb_q;
        m_fb_q <= freeb;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o            = '0;
    stat_o.is_free    = rtype_q;
    stat_o.addr_zero  = (faddr_q == '0);
    stat_o.no_room    = tot > XW'(freeb);
    stat_o.live_free  = !lvalid_q[lr_addr];
    stat_o.best_ok    = best_ok_q;
    stat_o.slot_ok    = slot_ok_q;
    stat_o.split_ok   = XW'(best_len_q) >= best_need_q + XW'(MIN_BLOCK_BYTES);
    stat_o.live_match = live_match;
    stat_o.below      = rbase < fblk_base_q;
    stat_o.join_prev  = prev_ok_q && ((prev_len_q + (AB+1)'(prev_base_q)) ==
                                      (AB+1)'(fblk_base_q));
    stat_o.join_next  = next_ok_q && ((fblk_len_q + (AB+1)'(fblk_base_q)) ==
                                      (AB+1)'(next_base_q));
    stat_o.full       = (cnt_q == CNW'(FREE_DEPTH));
    stat_o.out_busy   = out_valid_q && !m_tready_i;
    stat_o.cnt        = bfca_pkg::IdxW'(cnt_q);
    stat_o.best_idx   = bfca_pkg::IdxW'(best_idx_q);
  end

  assign m_tvalid_o    = out_valid_q;
  assign m_status_o    = m_st_q;
  assign m_data_addr_o = m_da_q;
  assign m_granted_o   = m_gb_q;
  assign m_free_o      = m_fb_q;

endmodule

// ===== rtl/bfca_controller.sv =====
// Controller: one-hot sequencer that walks the tables one entry per step.
// Issues bfca_pkg::dp_cmd_t to bfca_datapath and reads dp_stat_t; uses bfca_pkg.
module bfca_controller #(
  parameter int LIVE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  bfca_pkg::dp_stat_t  stat_i,
  output bfca_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_DECODE = 18'h00002,
    S_SLOT   = 18'h00004,
    S_FRD    = 18'h00008,
    S_FCALC  = 18'h00010,
    S_FEVAL  = 18'h00020,
    S_ADEC   = 18'h00040,
    S_SDN_RD = 18'h00080,
    S_SDN_WR = 18'h00100,
    S_LRD    = 18'h00200,
    S_LEV    = 18'h00400,
    S_PRD    = 18'h00800,
    S_PEV    = 18'h01000,
    S_PDEC   = 18'h02000,
    S_SUP_RD = 18'h04000,
    S_SUP_WR = 18'h08000,
    S_INS    = 18'h10000,
    S_FIN    = 18'h20000
  } state_e;

  localparam logic [bfca_pkg::IdxW-1:0] One     = bfca_pkg::IdxW'(1);
  localparam logic [bfca_pkg::IdxW-1:0] LiveEnd = bfca_pkg::IdxW'(LIVE_DEPTH - 1);

  state_e state_q, state_d;
  logic [bfca_pkg::IdxW-1:0] idx_q, idx_d, pos_q, pos_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    cmd_o.op   = bfca_pkg::CMD_NONE;
    cmd_o.code = bfca_pkg::ST_OK;
    cmd_o.idx  = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.op = bfca_pkg::CMD_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_d = '0;
        if (stat_i.is_free) begin
          if (stat_i.addr_zero) begin
            cmd_o.op = bfca_pkg::CMD_SET_RES;
            state_d  = S_FIN;
          end else begin
            state_d = S_LRD;
          end
        end else if (stat_i.no_room) begin
          cmd_o.op   = bfca_pkg::CMD_SET_RES;
          cmd_o.code = bfca_pkg::ST_NO_BYTES;
          state_d    = S_FIN;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd_o.op = bfca_pkg::CMD_SLOT;
        if (stat_i.live_free || (idx_q == LiveEnd)) begin
          idx_d   = '0;
          state_d = S_FRD;
        end else begin
          idx_d = idx_q + One;
        end
      end
      S_FRD: begin
        if (idx_q == stat_i.cnt) begin
          state_d = S_ADEC;
        end else begin
          cmd_o.op = bfca_pkg::CMD_FREAD;
          state_d  = S_FCALC;
        end
      end
      S_FCALC: begin
        cmd_o.op = bfca_pkg::CMD_FCALC;
        state_d  = S_FEVAL;
      end
      S_FEVAL: begin
        cmd_o.op = bfca_pkg::CMD_FEVAL;
        idx_d    = idx_q + One;
        state_d  = S_FRD;
      end
      S_ADEC: begin
        state_d = S_FIN;
        if (!stat_i.best_ok) begin
          cmd_o.op   = bfca_pkg::CMD_SET_RES;
          cmd_o.code = bfca_pkg::ST_NO_FIT;
        end else if (!stat_i.slot_ok) begin
          cmd_o.op   = bfca_pkg::CMD_SET_RES;
          cmd_o.code = bfca_pkg::ST_FULL;
        end else if (stat_i.split_ok) begin
          cmd_o.op = bfca_pkg::CMD_SPLIT;
        end else begin
          cmd_o.op = bfca_pkg::CMD_TAKE;
          idx_d    = stat_i.best_idx;
          state_d  = S_SDN_RD;
        end
      end
      S_SDN_RD: begin
        if (idx_q >= stat_i.cnt) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op  = bfca_pkg::CMD_FREAD;
          cmd_o.idx = idx_q + One;
          state_d   = S_SDN_WR;
        end
      end
      S_SDN_WR: begin
        cmd_o.op = bfca_pkg::CMD_FCOPY;
        idx_d    = idx_q + One;
        state_d  = S_SDN_RD;
      end
      S_LRD: begin
        cmd_o.op = bfca_pkg::CMD_LREAD;
        state_d  = S_LEV;
      end
      S_LEV: begin
        cmd_o.op = bfca_pkg::CMD_LEVAL;
        if (stat_i.live_match) begin
          idx_d   = '0;
          state_d = S_PRD;
        end else if (idx_q == LiveEnd) begin
          cmd_o.op   = bfca_pkg::CMD_SET_RES;
          cmd_o.code = bfca_pkg::ST_UNKNOWN;
          state_d    = S_FIN;
        end else begin
          idx_d   = idx_q + One;
          state_d = S_LRD;
        end
      end
      S_PRD: begin
        if (idx_q == stat_i.cnt) begin
          state_d = S_PDEC;
        end else begin
          cmd_o.op = bfca_pkg::CMD_FREAD;
          state_d  = S_PEV;
        end
      end
      S_PEV: begin
        cmd_o.op = bfca_pkg::CMD_PEVAL;
        if (stat_i.below) begin
          idx_d   = idx_q + One;
          state_d = S_PRD;
        end else begin
          state_d = S_PDEC;
        end
      end
      S_PDEC: begin
        state_d = S_FIN;
        pos_d   = idx_q;
        if (stat_i.join_prev && stat_i.join_next) begin
          cmd_o.op  = bfca_pkg::CMD_MERGE_BOTH;
          cmd_o.idx = idx_q - One;
          state_d   = S_SDN_RD;
        end else if (stat_i.join_prev) begin
          cmd_o.op  = bfca_pkg::CMD_MERGE_PREV;
          cmd_o.idx = idx_q - One;
        end else if (stat_i.join_next) begin
          cmd_o.op = bfca_pkg::CMD_MERGE_NEXT;
        end else if (stat_i.full) begin
          cmd_o.op   = bfca_pkg::CMD_SET_RES;
          cmd_o.code = bfca_pkg::ST_FULL;
        end else begin
          idx_d   = stat_i.cnt;
          state_d = S_SUP_RD;
        end
      end
      S_SUP_RD: begin
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else begin
          cmd_o.op  = bfca_pkg::CMD_FREAD;
          cmd_o.idx = idx_q - One;
          state_d   = S_SUP_WR;
        end
      end
      S_SUP_WR: begin
        cmd_o.op = bfca_pkg::CMD_FCOPY;
        idx_d    = idx_q - One;
        state_d  = S_SUP_RD;
      end
      S_INS: begin
        cmd_o.op = bfca_pkg::CMD_INSERT;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = bfca_pkg::CMD_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== rtl/best_fit_coalescing_allocator.sv =====
// Best-fit allocator with coalescing: top level, stream ports and config port.
// Allocate searches for a free live slot, scans every free extent, then shifts extents down
// when a block is taken whole; free scans live records and extents, then shifts extents.
// One request in flight; the next is taken once the result sits in the output register.
// Reset: arena is 2^ADDR_BITS as one free extent, no live records; no clearing pass.
module best_fit_coalescing_allocator #(
  parameter int ADDR_BITS       = 20,
  parameter int FREE_DEPTH      = 32,
  parameter int LIVE_DEPTH      = 64,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_BLOCK_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ADDR_BITS:0]   cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // req_size, align_log2, free_addr
  input  logic [((2 * ADDR_BITS + 5 + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // req_type
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // data_addr, granted_bytes, free_bytes
  output logic [((3 * ADDR_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // status
  output logic [2:0]           m_axis_tuser_o
);

  localparam int SDW = ((2 * ADDR_BITS + 5 + 7) / 8) * 8;
  localparam int MDW = ((3 * ADDR_BITS + 2 + 7) / 8) * 8;
  localparam int AB  = ADDR_BITS;

  bfca_pkg::dp_cmd_t  cmd;
  bfca_pkg::dp_stat_t stat;
  logic [AB-1:0] m_da;
  logic [AB:0]   m_gb, m_fb;

  bfca_controller #(.LIVE_DEPTH(LIVE_DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfca_datapath #(
    .ADDR_BITS       (ADDR_BITS),
    .FREE_DEPTH      (FREE_DEPTH),
    .LIVE_DEPTH      (LIVE_DEPTH),
    .HEADER_BYTES    (HEADER_BYTES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (s_axis_tuser_i),
    .req_size_i    (s_axis_tdata_i[AB:0]),
    .align_log2_i  (s_axis_tdata_i[AB+4:AB+1]),
    .free_addr_i   (s_axis_tdata_i[2*AB+4:AB+5]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_status_o    (m_axis_tuser_o),
    .m_data_addr_o (m_da),
    .m_granted_o   (m_gb),
    .m_free_o      (m_fb)
  );

  assign m_axis_tdata_o = MDW'({m_fb, m_gb, m_da});

endmodule

// ===== rtl/bfca_checker.sv =====
// Port-level checker for best_fit_coalescing_allocator, with its bind.
// Depends on bfca_pkg for result codes.
module bfca_checker #(
  parameter int ADDR_BITS = 20,
  parameter int MDW       = 64
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid_i,
  input logic           s_axis_tready_o,
  input logic           m_axis_tvalid_o,
  input logic           m_axis_tready_i,
  input logic [MDW-1:0] m_axis_tdata_o,
  input logic [2:0]     m_axis_tuser_o
);

  localparam int AB = ADDR_BITS;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped while stalled");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= bfca_pkg::ST_FULL)
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != bfca_pkg::ST_OK) |->
      (m_axis_tdata_o[2*AB:0] == '0))
    else $error("failed request carries address or bytes");

  a_free_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[3*AB+1:2*AB+1] <= {1'b1, {AB{1'b0}}})
    else $error("free bytes above arena limit");

endmodule

bind best_fit_coalescing_allocator bfca_checker #(
  .ADDR_BITS (ADDR_BITS),
  .MDW       (MDW)
) u_bfca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for best_fit_coalescing_allocator.
// Holds its own allocator predictor in a scoreboard class and drives random and directed
// allocate/free transactions with random stalls. Depends on bfca_pkg and the RTL top.
module tb_top;

  localparam int SDW = 48;
  localparam int MDW = 64;
  localparam longint unsigned ARENA_MAX = 64'd1 << 20;
  localparam int NFREE = 32;
  localparam int NLIVE = 64;
  localparam int HDR = 16;
  localparam int MINBLK = 32;
  localparam bit OP_ALLOC = 1'b0;
  localparam bit OP_FREE = 1'b1;

  typedef struct {
    bit          kind;
    logic [20:0] size;
    logic [3:0]  align;
    logic [19:0] addr;
  } req_t;

  typedef struct {
    bfca_pkg::status_e status;
    logic [19:0] data_addr;
    logic [20:0] granted;
    logic [20:0] free_bytes;
  } resp_t;

  class alloc_scoreboard;
    longint unsigned arena, in_use;
    longint unsigned ext_base[NFREE], ext_len[NFREE];
    int ext_cnt;
    longint unsigned rec_data[NLIVE], rec_base[NLIVE], rec_len[NLIVE];
    bit rec_valid[NLIVE];
    resp_t pending[$];
    int errors;

    function void configure(longint unsigned v);
      arena = (v > ARENA_MAX) ? ARENA_MAX : v;
      foreach (rec_valid[i]) rec_valid[i] = 0;
      ext_base[0] = 0;
      ext_len[0] = arena;
      ext_cnt = (arena != 0) ? 1 : 0;
      in_use = 0;
    endfunction

    function void drop_extent(int i);
      for (int k = i; k + 1 < ext_cnt; k++) begin
        ext_base[k] = ext_base[k+1];
        ext_len[k] = ext_len[k+1];
      end
      ext_cnt--;
    endfunction

    function void push(bfca_pkg::status_e st, longint unsigned da, longint unsigned gb);
      resp_t r;
      r.status = st;
      r.data_addr = da[19:0];
      r.granted = gb[20:0];
      r.free_bytes = 21'(arena - in_use);
      pending.push_back(r);
    endfunction

    function void allocate(req_t q);
      longint unsigned sz, a, d, need, best_len, best_need, best_data, b, l, g;
      int best, slot;
      sz = (q.size == 0) ? 1 : q.size;
      a = 64'd1 << q.align;
      best = -1;
      slot = -1;
      best_len = 0;
      best_need = 0;
      best_data = 0;
      if (((sz + HDR + a - 1) & ~(a - 1)) > arena - in_use) begin
        push(bfca_pkg::ST_NO_BYTES, 0, 0);
        return;
      end
      for (int i = 0; i < ext_cnt; i++) begin
        d = (ext_base[i] + HDR + a - 1) & ~(a - 1);
        need = d - ext_base[i] + sz;
        if (ext_len[i] >= need && (best < 0 || ext_len[i] < best_len)) begin
          best = i;
          best_len = ext_len[i];
          best_need = need;
          best_data = d;
        end
      end
      if (best < 0) begin
        push(bfca_pkg::ST_NO_FIT, 0, 0);
        return;
      end
      for (int i = 0; i < NLIVE; i++)
        if (!rec_valid[i] && slot < 0) slot = i;
      if (slot < 0) begin
        push(bfca_pkg::ST_FULL, 0, 0);
        return;
      end
      b = ext_base[best];
      l = ext_len[best];
      if (l >= best_need + MINBLK) begin
        ext_base[best] = b + best_need;
        ext_len[best] = l - best_need;
        g = best_need;
      end else begin
        drop_extent(best);
        g = l;
      end
      rec_valid[slot] = 1;
      rec_data[slot] = best_data;
      rec_base[slot] = b;
      rec_len[slot] = g;
      in_use += g;
      push(bfca_pkg::ST_OK, best_data, g);
    endfunction

    function void release_block(req_t q);
      longint unsigned b, l;
      int slot, pos;
      bit jp, jn;
      slot = -1;
      if (q.addr == 0) begin
        push(bfca_pkg::ST_OK, 0, 0);
        return;
      end
      for (int i = 0; i < NLIVE; i++)
        if (slot < 0 && rec_valid[i] && rec_data[i] == q.addr) slot = i;
      if (slot < 0) begin
        push(bfca_pkg::ST_UNKNOWN, 0, 0);
        return;
      end
      b = rec_base[slot];
      l = rec_len[slot];
      pos = 0;
      while (pos < ext_cnt && ext_base[pos] < b) pos++;
      jp = pos > 0 && ext_base[pos-1] + ext_len[pos-1] == b;
      jn = pos < ext_cnt && b + l == ext_base[pos];
      if (!jp && !jn && ext_cnt >= NFREE) begin
        push(bfca_pkg::ST_FULL, 0, 0);
        return;
      end
      if (jp && jn) begin
        ext_len[pos-1] += l + ext_len[pos];
        drop_extent(pos);
      end else if (jp) begin
        ext_len[pos-1] += l;
      end else if (jn) begin
        ext_base[pos] = b;
        ext_len[pos] += l;
      end else begin
        for (int i = ext_cnt; i > pos; i--) begin
          ext_base[i] = ext_base[i-1];
          ext_len[i] = ext_len[i-1];
        end
        ext_base[pos] = b;
        ext_len[pos] = l;
        ext_cnt++;
      end
      rec_valid[slot] = 0;
      in_use -= l;
      push(bfca_pkg::ST_OK, 0, l);
    endfunction

    function void note_request(req_t q);
      if (q.kind == OP_ALLOC) allocate(q);
      else release_block(q);
    endfunction

    function void check_result(resp_t got);
      resp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d", got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp=%0d got=%0d", e.status, got.status);
        errors++;
      end
      if (got.data_addr !== e.data_addr) begin
        $error("data_addr exp=%0h got=%0h", e.data_addr, got.data_addr);
        errors++;
      end
      if (got.granted !== e.granted) begin
        $error("granted_bytes exp=%0d got=%0d", e.granted, got.granted);
        errors++;
      end
      if (got.free_bytes !== e.free_bytes) begin
        $error("free_bytes exp=%0d got=%0d", e.free_bytes, got.free_bytes);
        errors++;
      end
    endfunction

    function logic [19:0] pick_live();
      int idx[$];
      for (int i = 0; i < NLIVE; i++)
        if (rec_valid[i]) idx.push_back(i);
      if (idx.size() == 0) return 20'd0;
      return rec_data[idx[$urandom_range(0, idx.size() - 1)]][19:0];
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [20:0] cfg_wdata_i;
  logic s_axis_tvalid_i, s_axis_tready_o, s_axis_tuser_i;
  logic [SDW-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [MDW-1:0] m_axis_tdata_o;
  logic [2:0] m_axis_tuser_o;

  alloc_scoreboard sb;
  bit calm;
  int stall_left;

  best_fit_coalescing_allocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("[best_fit_coalescing_allocator] ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    resp_t got;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status = bfca_pkg::status_e'(m_axis_tuser_o);
        got.data_addr = m_axis_tdata_o[19:0];
        got.granted = m_axis_tdata_o[40:20];
        got.free_bytes = m_axis_tdata_o[61:41];
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        stall_left = gap_len();
        m_axis_tready_i <= (stall_left == 0);
      end
    end
  end

  task automatic send(req_t q);
    int n;
    n = gap_len();
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= q.kind;
    s_axis_tdata_i <= {3'b0, q.addr, q.align, q.size};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(q);
  endtask

  task automatic send_alloc(int sz, int al);
    req_t q;
    q.kind = OP_ALLOC;
    q.size = 21'(sz);
    q.align = 4'(al);
    q.addr = 20'($urandom);
    send(q);
  endtask

  task automatic send_free(logic [19:0] a);
    req_t q;
    q.kind = OP_FREE;
    q.size = 21'($urandom);
    q.align = 4'($urandom);
    q.addr = a;
    send(q);
  endtask

  task automatic write_arena(int unsigned v);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 21'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.configure(v);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if ($urandom_range(0, 9) < 8) send_alloc($urandom_range(0, 256), $urandom_range(0, 6));
      else if ($urandom_range(0, 3) != 0)
        send_alloc($urandom_range(1, 8192), $urandom_range(0, 15));
      else send_alloc($urandom_range(0, 21'h1FFFFF), $urandom_range(0, 15));
    end else if (r < 88) send_free(sb.pick_live());
    else if (r < 94) send_free(20'($urandom));
    else send_free(20'd0);
  endtask

  // fill the live table, then free every other record to fragment the free list, then free the rest
  task automatic fragment();
    logic [19:0] offs[NLIVE];
    for (int i = 0; i < NLIVE + 2; i++) send_alloc($urandom_range(1, 16), 0);
    for (int i = 0; i < NLIVE; i++) offs[i] = sb.rec_data[i][19:0];
    for (int i = 0; i < NLIVE; i += 2) send_free(offs[i]);
    for (int i = 1; i < NLIVE; i += 2) send_free(offs[i]);
  endtask

  initial begin
    int unsigned arenas[6] = '{1048576, 4096, 0, 2097151, 100000, 1048576};
    sb = new();
    sb.configure(ARENA_MAX);
    calm = 1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_alloc(0, 0);
    send_alloc(1, 15);
    send_alloc(21'h1FFFFF, 0);
    send_alloc(1048576, 0);
    send_alloc(1000, 12);
    send_alloc(77, 3);
    send_free(20'd0);
    send_free(20'hFFFFF);
    send_free(sb.pick_live());
    send_free(sb.pick_live());
    send_alloc(5000, 7);
    send_free(sb.pick_live());
    send_free(sb.pick_live());
    send_alloc(1048576 - 16, 0);
    send_free(sb.pick_live());
    send_alloc(0, 4);
    send_free(20'h55555);
    send_free(20'hAAAAA);

    foreach (arenas[p]) begin
      write_arena(arenas[p]);
      calm = (p == 1);
      if (p == 1 || p == 4) fragment();
      for (int i = 0; i < 70; i++) random_item();
    end

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[best_fit_coalescing_allocator] OK");
    else
      $display("[best_fit_coalescing_allocator] ERROR");
    $finish;
  end
endmodule
